FILE: design/mni_pkg.sv
// Shared types, codes and saturation helpers for the neighbor interaction block.
// No dependencies; used by mps_neighbor_interaction and the testbench.
`default_nettype none

package mni_pkg;

  localparam int unsigned FRAC_BITS = 16;

  typedef logic signed [31:0] q_t;

  localparam q_t Q_MAX = 32'sh7fffffff;
  localparam q_t Q_MIN = 32'sh80000000;

  localparam logic [2:0] ACT_LOAD   = 3'd0;
  localparam logic [2:0] ACT_DENS   = 3'd1;
  localparam logic [2:0] ACT_LAMBDA = 3'd2;
  localparam logic [2:0] ACT_PGRAD  = 3'd3;
  localparam logic [2:0] ACT_VISC   = 3'd4;

  localparam logic [1:0] CFG_RADIUS  = 2'd0;
  localparam logic [1:0] CFG_DENSITY = 2'd1;
  localparam logic [1:0] CFG_LAMBDA  = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_DIFF, S_SQ, S_SQACC, S_RCMP, S_RCHK, S_SQRTW, S_WDIV,
    S_L0, S_L1, S_L2, S_A3, S_A3B, S_A3C, S_A4, S_A4B, S_COE,
    S_AX0, S_AX1, S_AX2, S_QMUL, S_QMULR, S_QDIV, S_QDIVW, S_FIN
  } state_e;

  function automatic q_t sat33(input logic signed [32:0] s);
    q_t r;
    if (s[32] != s[31]) r = s[32] ? Q_MIN : Q_MAX;
    else r = s[31:0];
    return r;
  endfunction

  function automatic q_t add_sat(input q_t a, input q_t b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    return sat33(s);
  endfunction

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  function automatic q_t signed_mag(input logic neg, input logic [65:0] m);
    q_t r;
    if (neg) r = (m > 66'h80000000) ? Q_MIN : q_t'(-m[31:0]);
    else r = (m > 66'h7fffffff) ? Q_MAX : q_t'(m[31:0]);
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/mni_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on nothing; used by mps_neighbor_interaction.
`default_nettype none

module mni_div #(
  parameter int unsigned DW = 48,
  parameter int unsigned VW = 33
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [VW-1:0] divisor_i,
  output logic               done_o,
  output logic [DW-1:0]      quot_o
);

  localparam int unsigned CW = $clog2(DW);
  localparam logic [CW-1:0] LAST = CW'(DW - 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] dvd_q;
  logic [VW-1:0] dvs_q, rem_q;
  logic [VW:0]   rem_t, rem_n;
  logic          ge;

  always_comb begin
    rem_t = {rem_q, dvd_q[DW-1]};
    ge    = rem_t >= {1'b0, dvs_q};
    rem_n = ge ? rem_t - {1'b0, dvs_q} : rem_t;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      dvd_q  <= '0;
      dvs_q  <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        dvd_q  <= dividend_i;
        dvs_q  <= divisor_i;
        rem_q  <= '0;
      end else if (busy_q) begin
        dvd_q <= {dvd_q[DW-2:0], ge};
        rem_q <= rem_n[VW-1:0];
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

`default_nettype wire

FILE: design/mni_sqrt.sv
// Integer square root of a 64-bit value, one root bit per cycle.
// Depends on nothing; used by mps_neighbor_interaction.
`default_nettype none

module mni_sqrt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] rad_i,
  output logic             done_o,
  output logic [31:0]      root_o
);

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [63:0] rad_q;
  logic [31:0] root_q;
  logic [33:0] rem_q;
  logic [35:0] rem_t, trial;
  logic        ge;

  always_comb begin
    rem_t = {rem_q, rad_q[63:62]};
    trial = {2'b00, root_q, 2'b01};
    ge    = rem_t >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rad_q  <= '0;
      root_q <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rad_q  <= rad_i;
        root_q <= '0;
        rem_q  <= '0;
      end else if (busy_q) begin
        rad_q  <= {rad_q[61:0], 2'b00};
        rem_q  <= ge ? 34'(rem_t - trial) : rem_t[33:0];
        root_q <= {root_q[30:0], ge};
        cnt_q  <= cnt_q + 1'b1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

FILE: design/mps_neighbor_interaction.sv
// Channel | handshake              | payload
// in      | in_valid_i/in_stall_o  | action, pos/vel xyz, pressure, last_neighbor
// out     | out_valid_o/out_stall_i| sums, forces, zero_distance, done_res
// cfg     | cfg_we_i               | cfg_idx_i, cfg_data_i
// Load and unused actions skip the arithmetic. A neighbor at nonzero distance within
// the radius runs the square root, then one to three divisions on the shared divider,
// plus multiplier steps on the shared multiplier.
// in_stall_o is high while an item is in work; a result waiting in the output
// register does not block the next transfer in. Reset clears all state but the product register.
// Depends on mni_pkg, mni_div, mni_sqrt.
`default_nettype none

module mps_neighbor_interaction #(
  parameter int unsigned FRAC_BITS = mni_pkg::FRAC_BITS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [30:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  action_i,
  input  wire logic signed [31:0] pos_x_i,
  input  wire logic signed [31:0] pos_y_i,
  input  wire logic signed [31:0] pos_z_i,
  input  wire logic signed [31:0] vel_x_i,
  input  wire logic signed [31:0] vel_y_i,
  input  wire logic signed [31:0] vel_z_i,
  input  wire logic signed [31:0] pressure_in_i,
  input  wire logic        last_neighbor_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic signed [31:0] density_sum_o,
  output logic signed [31:0] lambda_sum_o,
  output logic signed [31:0] force_x_o,
  output logic signed [31:0] force_y_o,
  output logic signed [31:0] force_z_o,
  output logic             zero_distance_o,
  output logic             done_res_o
);

  localparam int unsigned DW = 32 + FRAC_BITS;
  localparam int unsigned VW = 33;
  localparam logic [30:0] ONE_CFG = 31'(1) << FRAC_BITS;
  localparam logic signed [32:0] TWO_Q = 33'(2) << FRAC_BITS;
  localparam logic signed [32:0] FOUR_Q = 33'(4) << FRAC_BITS;
  localparam logic [DW-1:0] ONE_W = DW'(1) << FRAC_BITS;

  mni_pkg::state_e state_q, state_d, ret_q;

  logic [30:0] re_q, n0_q, l0_q;
  mni_pkg::q_t sp_q [3];
  mni_pkg::q_t sv_q [3];
  mni_pkg::q_t p_q [3];
  mni_pkg::q_t v_q [3];
  mni_pkg::q_t frc_q [3];
  mni_pkg::q_t spr_q, pr_q, dens_q, lam_q, tmp_q, coe_q;
  logic [2:0]  act_q;
  logic        last_q, zero_q, neg_q;
  logic signed [32:0] d_q [3];
  logic signed [32:0] qa_q, qb_q;
  logic [65:0] d2_q, prod_q, lo_q, d2q_w;
  logic [30:0] w_q;
  logic [1:0]  idx_q;

  logic        out_valid_q, in_xfer, out_free;
  logic        zero_out_q, done_out_q;
  mni_pkg::q_t o_dens_q, o_lam_q, o_fx_q, o_fy_q, o_fz_q;

  logic [32:0] mul_a, mul_b, qma, qmb;
  logic        div_start, div_done, sq_start, sq_done;
  logic [DW-1:0] div_dvd, div_quot;
  logic [VW-1:0] div_dvs;
  logic [31:0] sq_root;
  logic        over, in_range;
  mni_pkg::q_t dd, dp, ax_in, w_new;
  logic [97:0] ltot, lsh;

  assign in_stall_o = (state_q != mni_pkg::S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign d2q_w    = d2_q >> FRAC_BITS;
  assign over     = |d2_q[65:64];
  assign in_range = !over && (d2_q <= prod_q);
  assign qma      = mni_pkg::mag33(qa_q);
  assign qmb      = mni_pkg::mag33(qb_q);
  assign dd = (|d2q_w[65:31]) ? mni_pkg::Q_MAX : mni_pkg::q_t'({1'b0, d2q_w[30:0]});
  assign dp = mni_pkg::sat33({pr_q[31], pr_q} - {spr_q[31], spr_q});
  assign ax_in = (act_q == mni_pkg::ACT_PGRAD) ? mni_pkg::sat33(d_q[idx_q]) :
      mni_pkg::sat33({v_q[idx_q][31], v_q[idx_q]} - {sv_q[idx_q][31], sv_q[idx_q]});
  assign ltot = ({32'b0, prod_q} << 32) + 98'(lo_q);
  assign lsh  = ltot >> FRAC_BITS;

  always_comb begin
    if (div_quot < ONE_W) w_new = '0;
    else if (|((div_quot - ONE_W) >> 31)) w_new = mni_pkg::Q_MAX;
    else w_new = mni_pkg::q_t'({1'b0, 31'(div_quot - ONE_W)});
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      mni_pkg::S_SQ: begin
        mul_a = mni_pkg::mag33(d_q[idx_q]);
        mul_b = mni_pkg::mag33(d_q[idx_q]);
      end
      mni_pkg::S_RCMP: begin
        mul_a = {2'b0, re_q};
        mul_b = {2'b0, re_q};
      end
      mni_pkg::S_QMUL: begin
        mul_a = qma;
        mul_b = qmb;
      end
      mni_pkg::S_L0: begin
        mul_a = {1'b0, d2q_w[31:0]};
        mul_b = {2'b0, w_q};
      end
      mni_pkg::S_L1: begin
        mul_a = {1'b0, d2q_w[63:32]};
        mul_b = {2'b0, w_q};
      end
      default: ;
    endcase
  end

  always_comb begin
    sq_start  = (state_q == mni_pkg::S_RCHK) && (d2_q != '0) && in_range;
    div_start = 1'b0;
    div_dvd   = DW'({re_q, FRAC_BITS'(0)});
    div_dvs   = {2'b0, sq_root[30:0]};
    if (state_q == mni_pkg::S_SQRTW) begin
      div_start = sq_done;
      div_dvs   = {1'b0, sq_root};
    end else if (state_q == mni_pkg::S_QDIV) begin
      div_start = (qma != '0) && (qmb != '0);
      div_dvd   = DW'(qma) << FRAC_BITS;
      div_dvs   = qmb;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mni_pkg::S_IDLE: begin
        if (in_xfer) begin
          if (action_i == mni_pkg::ACT_LOAD) state_d = mni_pkg::S_LOAD;
          else if (action_i > mni_pkg::ACT_VISC) state_d = mni_pkg::S_FIN;
          else state_d = mni_pkg::S_DIFF;
        end
      end
      mni_pkg::S_LOAD:  state_d = mni_pkg::S_FIN;
      mni_pkg::S_DIFF:  state_d = mni_pkg::S_SQ;
      mni_pkg::S_SQ:    state_d = mni_pkg::S_SQACC;
      mni_pkg::S_SQACC: state_d = (idx_q == 2'd2) ? mni_pkg::S_RCMP : mni_pkg::S_SQ;
      mni_pkg::S_RCMP:  state_d = mni_pkg::S_RCHK;
      mni_pkg::S_RCHK:  state_d = sq_start ? mni_pkg::S_SQRTW : mni_pkg::S_FIN;
      mni_pkg::S_SQRTW: if (sq_done) state_d = mni_pkg::S_WDIV;
      mni_pkg::S_WDIV: begin
        if (div_done) begin
          unique case (act_q)
            mni_pkg::ACT_LAMBDA: state_d = mni_pkg::S_L0;
            mni_pkg::ACT_PGRAD:  state_d = mni_pkg::S_A3;
            mni_pkg::ACT_VISC:   state_d = mni_pkg::S_A4;
            default:             state_d = mni_pkg::S_FIN;
          endcase
        end
      end
      mni_pkg::S_L0:   state_d = mni_pkg::S_L1;
      mni_pkg::S_L1:   state_d = mni_pkg::S_L2;
      mni_pkg::S_L2:   state_d = mni_pkg::S_FIN;
      mni_pkg::S_A3:   state_d = mni_pkg::S_QDIV;
      mni_pkg::S_A3B:  state_d = mni_pkg::S_QMUL;
      mni_pkg::S_A3C:  state_d = mni_pkg::S_QDIV;
      mni_pkg::S_A4:   state_d = mni_pkg::S_QMUL;
      mni_pkg::S_A4B:  state_d = mni_pkg::S_QDIV;
      mni_pkg::S_COE:  state_d = mni_pkg::S_AX0;
      mni_pkg::S_AX0:  state_d = mni_pkg::S_QMUL;
      mni_pkg::S_AX1:  state_d = mni_pkg::S_QMUL;
      mni_pkg::S_AX2:  state_d = (idx_q == 2'd2) ? mni_pkg::S_FIN : mni_pkg::S_AX0;
      mni_pkg::S_QMUL: state_d = mni_pkg::S_QMULR;
      mni_pkg::S_QMULR: state_d = ret_q;
      mni_pkg::S_QDIV: state_d = div_start ? mni_pkg::S_QDIVW : ret_q;
      mni_pkg::S_QDIVW: if (div_done) state_d = ret_q;
      mni_pkg::S_FIN:  if (out_free) state_d = mni_pkg::S_IDLE;
      default:         state_d = mni_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= mni_pkg::S_IDLE;
    else state_q <= state_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      re_q <= ONE_CFG;
      n0_q <= ONE_CFG;
      l0_q <= ONE_CFG;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mni_pkg::CFG_RADIUS:  re_q <= cfg_data_i;
        mni_pkg::CFG_DENSITY: n0_q <= cfg_data_i;
        mni_pkg::CFG_LAMBDA:  l0_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 66'(mul_a) * 66'(mul_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        sp_q[i]  <= '0;
        sv_q[i]  <= '0;
        frc_q[i] <= '0;
        p_q[i]   <= '0;
        v_q[i]   <= '0;
        d_q[i]   <= '0;
      end
      spr_q  <= '0;
      dens_q <= '0;
      lam_q  <= '0;
      pr_q   <= '0;
      act_q  <= '0;
      last_q <= 1'b0;
      zero_q <= 1'b0;
      neg_q  <= 1'b0;
      qa_q   <= '0;
      qb_q   <= '0;
      d2_q   <= '0;
      lo_q   <= '0;
      w_q    <= '0;
      idx_q  <= '0;
      tmp_q  <= '0;
      coe_q  <= '0;
      ret_q  <= mni_pkg::S_IDLE;
    end else begin
      unique case (state_q)
        mni_pkg::S_IDLE: begin
          if (in_xfer) begin
            act_q  <= action_i;
            p_q[0] <= pos_x_i;
            p_q[1] <= pos_y_i;
            p_q[2] <= pos_z_i;
            v_q[0] <= vel_x_i;
            v_q[1] <= vel_y_i;
            v_q[2] <= vel_z_i;
            pr_q   <= pressure_in_i;
            last_q <= last_neighbor_i;
            zero_q <= 1'b0;
          end
        end
        mni_pkg::S_LOAD: begin
          for (int i = 0; i < 3; i++) begin
            sp_q[i]  <= p_q[i];
            sv_q[i]  <= v_q[i];
            frc_q[i] <= '0;
          end
          spr_q  <= pr_q;
          dens_q <= '0;
          lam_q  <= '0;
        end
        mni_pkg::S_DIFF: begin
          for (int i = 0; i < 3; i++) d_q[i] <= {p_q[i][31], p_q[i]} - {sp_q[i][31], sp_q[i]};
          d2_q  <= '0;
          idx_q <= '0;
        end
        mni_pkg::S_SQACC: begin
          d2_q  <= d2_q + prod_q;
          idx_q <= idx_q + 1'b1;
        end
        mni_pkg::S_RCHK: begin
          if (!over && d2_q == '0) zero_q <= 1'b1;
        end
        mni_pkg::S_WDIV: begin
          if (div_done) begin
            w_q <= w_new[30:0];
            if (act_q == mni_pkg::ACT_DENS) dens_q <= mni_pkg::add_sat(dens_q, w_new);
          end
        end
        mni_pkg::S_L1: lo_q <= prod_q;
        mni_pkg::S_L2: begin
          lam_q <= mni_pkg::add_sat(lam_q, (|lsh[97:31]) ? mni_pkg::Q_MAX :
              mni_pkg::q_t'({1'b0, lsh[30:0]}));
        end
        mni_pkg::S_A3: begin
          qa_q  <= TWO_Q;
          qb_q  <= {2'b0, n0_q};
          ret_q <= mni_pkg::S_A3B;
        end
        mni_pkg::S_A3B: begin
          qa_q  <= {tmp_q[31], tmp_q};
          qb_q  <= {dp[31], dp};
          ret_q <= mni_pkg::S_A3C;
        end
        mni_pkg::S_A3C: begin
          qa_q  <= {tmp_q[31], tmp_q};
          qb_q  <= {dd[31], dd};
          ret_q <= mni_pkg::S_COE;
        end
        mni_pkg::S_A4: begin
          qa_q  <= {2'b0, n0_q};
          qb_q  <= {2'b0, l0_q};
          ret_q <= mni_pkg::S_A4B;
        end
        mni_pkg::S_A4B: begin
          qa_q  <= FOUR_Q;
          qb_q  <= {tmp_q[31], tmp_q};
          ret_q <= mni_pkg::S_COE;
        end
        mni_pkg::S_COE: begin
          coe_q <= tmp_q;
          idx_q <= '0;
        end
        mni_pkg::S_AX0: begin
          qa_q  <= {coe_q[31], coe_q};
          qb_q  <= {ax_in[31], ax_in};
          ret_q <= mni_pkg::S_AX1;
        end
        mni_pkg::S_AX1: begin
          qa_q  <= {tmp_q[31], tmp_q};
          qb_q  <= {2'b0, w_q};
          ret_q <= mni_pkg::S_AX2;
        end
        mni_pkg::S_AX2: begin
          frc_q[idx_q] <= mni_pkg::add_sat(frc_q[idx_q], tmp_q);
          idx_q <= idx_q + 1'b1;
        end
        mni_pkg::S_QMUL: neg_q <= qa_q[32] != qb_q[32];
        mni_pkg::S_QMULR: tmp_q <= mni_pkg::signed_mag(neg_q, prod_q >> FRAC_BITS);
        mni_pkg::S_QDIV: begin
          neg_q <= qa_q[32] != qb_q[32];
          if (qma == '0) tmp_q <= '0;
          else if (qmb == '0) tmp_q <= qa_q[32] ? mni_pkg::Q_MIN : mni_pkg::Q_MAX;
        end
        mni_pkg::S_QDIVW: begin
          if (div_done) tmp_q <= mni_pkg::signed_mag(neg_q, 66'(div_quot));
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      o_dens_q    <= '0;
      o_lam_q     <= '0;
      o_fx_q      <= '0;
      o_fy_q      <= '0;
      o_fz_q      <= '0;
      zero_out_q  <= 1'b0;
      done_out_q  <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (state_q == mni_pkg::S_FIN && out_free) begin
        out_valid_q <= 1'b1;
        o_dens_q    <= dens_q;
        o_lam_q     <= lam_q;
        o_fx_q      <= frc_q[0];
        o_fy_q      <= frc_q[1];
        o_fz_q      <= frc_q[2];
        zero_out_q  <= zero_q;
        done_out_q  <= last_q;
      end
    end
  end

  mni_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (d2_q[63:0]),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  mni_div #(.DW(DW), .VW(VW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign out_valid_o     = out_valid_q;
  assign density_sum_o   = o_dens_q;
  assign lambda_sum_o    = o_lam_q;
  assign force_x_o       = o_fx_q;
  assign force_y_o       = o_fy_q;
  assign force_z_o       = o_fz_q;
  assign zero_distance_o = zero_out_q;
  assign done_res_o      = done_out_q;

endmodule

`default_nettype wire

FILE: design/mni_chk.sv
// Port-level checks for mps_neighbor_interaction, attached by bind.
// Depends on the top level's port list only.
`default_nettype none

module mni_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [31:0] density_sum_o
);

  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("not busy after input transfer");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
      $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without item in work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result dropped");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && out_stall_i |=> $stable(density_sum_o))
    else $error("stalled result changed");

endmodule

bind mps_neighbor_interaction mni_chk u_mni_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .density_sum_o (density_sum_o)
);

`default_nettype wire

FILE: sim/mps_neighbor_interaction_tb.sv
// Self-checking testbench for mps_neighbor_interaction: a directed table, then random
// particle/neighbor streams under several radius/density/lambda settings with bursty input
// and random output stalls. Depends on mni_pkg and the block's RTL.
`default_nettype none

module mps_neighbor_interaction_tb;

  localparam int unsigned F = mni_pkg::FRAC_BITS;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam logic [2:0] ACT_SPARE5 = 3'd5;
  localparam logic [2:0] ACT_SPARE7 = 3'd7;
  localparam longint ONE = longint'(1) << F;
  localparam longint I32MAX = 64'sd2147483647;
  localparam longint I32MIN = -64'sd2147483648;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    mni_pkg::q_t dens;
    mni_pkg::q_t lam;
    mni_pkg::q_t fx;
    mni_pkg::q_t fy;
    mni_pkg::q_t fz;
    logic        zero;
    logic        done;
  } sums_t;

  typedef struct {
    logic [2:0]  act;
    mni_pkg::q_t px, py, pz, vx, vy, vz, pr;
    logic        last;
    bit          typed;
    sums_t       want;
  } row_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [30:0] cfg_data_i;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic [2:0] action_i;
  mni_pkg::q_t pos_x_i, pos_y_i, pos_z_i, vel_x_i, vel_y_i, vel_z_i, pressure_in_i;
  logic last_neighbor_i;
  mni_pkg::q_t density_sum_o, lambda_sum_o, force_x_o, force_y_o, force_z_o;
  logic zero_distance_o, done_res_o;

  mps_neighbor_interaction DUT (.*);

  // model state
  logic [30:0] radius_q, density_q, lambda_q;
  mni_pkg::q_t self_pos [3];
  mni_pkg::q_t self_vel [3];
  mni_pkg::q_t self_pr;
  mni_pkg::q_t dens_acc, lam_acc;
  mni_pkg::q_t force_acc [3];

  sums_t pending_sums [$];
  bit    use_typed;
  sums_t typed_sums;
  int    fails;
  int    idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic mni_pkg::q_t sat64(longint v);
    if (v > I32MAX) return mni_pkg::Q_MAX;
    if (v < I32MIN) return mni_pkg::Q_MIN;
    return mni_pkg::q_t'(v);
  endfunction

  function automatic mni_pkg::q_t from_mag(bit neg, logic [63:0] m);
    if (neg) return (m > 64'h80000000) ? mni_pkg::Q_MIN : sat64(-longint'(m));
    return (m > 64'h7fffffff) ? mni_pkg::Q_MAX : mni_pkg::q_t'(m);
  endfunction

  function automatic mni_pkg::q_t fx_mul(longint a, longint b);
    logic [63:0] ma, mb;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    return from_mag((a < 0) != (b < 0), (ma * mb) >> F);
  endfunction

  function automatic mni_pkg::q_t fx_div(longint a, longint b);
    logic [63:0] ma, mb;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    if (ma == 0) return '0;
    if (mb == 0) return a < 0 ? mni_pkg::Q_MIN : mni_pkg::Q_MAX;
    return from_mag((a < 0) != (b < 0), (ma << F) / mb);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] root, probe;
    root = 0;
    probe = 64'h1 << 62;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v = v - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  function automatic void add_to(ref mni_pkg::q_t acc, input longint term);
    acc = sat64(longint'(acc) + term);
  endfunction

  function automatic sums_t interact(logic [2:0] act, mni_pkg::q_t p [3],
                                     mni_pkg::q_t v [3], mni_pkg::q_t pr, logic last);
    sums_t s;
    longint d [3];
    logic [65:0] d2;
    logic [63:0] m, r, q, d2q;
    logic [127:0] prod;
    longint w;
    mni_pkg::q_t coe, dp, dd, k, nl;
    bit flag;
    flag = 0;
    if (act == mni_pkg::ACT_LOAD) begin
      for (int i = 0; i < 3; i++) begin
        self_pos[i] = p[i];
        self_vel[i] = v[i];
        force_acc[i] = '0;
      end
      self_pr = pr;
      dens_acc = '0;
      lam_acc = '0;
    end else if (act <= mni_pkg::ACT_VISC) begin
      d2 = 0;
      for (int i = 0; i < 3; i++) begin
        d[i] = longint'(p[i]) - longint'(self_pos[i]);
        m = d[i] < 0 ? -d[i] : d[i];
        d2 = d2 + 66'(m * m);
      end
      if (d2 == 0) begin
        flag = 1;
      end else if (d2 <= 66'(64'(radius_q) * 64'(radius_q))) begin
        r = int_sqrt(d2[63:0]);
        q = (64'(radius_q) << F) / r;
        w = longint'(q) - ONE;
        if (w > I32MAX) w = I32MAX;
        if (w < 0) w = 0;
        d2q = d2[63:0] >> F;
        case (act)
          mni_pkg::ACT_DENS: add_to(dens_acc, w);
          mni_pkg::ACT_LAMBDA: begin
            prod = 128'(d2q) * 128'(w);
            if (prod[127:64] != 0) prod = 128'(64'hffffffffffffffff);
            prod = prod >> F;
            add_to(lam_acc, prod > 128'(I32MAX) ? I32MAX : longint'(prod[63:0]));
          end
          mni_pkg::ACT_PGRAD: begin
            coe = fx_div(2 * ONE, longint'(density_q));
            dp = sat64(longint'(pr) - longint'(self_pr));
            dd = (d2q > 64'(I32MAX)) ? mni_pkg::Q_MAX : mni_pkg::q_t'(d2q);
            k = fx_div(fx_mul(coe, dp), dd);
            for (int i = 0; i < 3; i++)
              add_to(force_acc[i], fx_mul(fx_mul(k, sat64(d[i])), w));
          end
          default: begin
            nl = fx_mul(longint'(density_q), longint'(lambda_q));
            coe = fx_div(4 * ONE, nl);
            for (int i = 0; i < 3; i++)
              add_to(force_acc[i], fx_mul(fx_mul(coe,
                     sat64(longint'(v[i]) - longint'(self_vel[i]))), w));
          end
        endcase
      end
    end
    s.dens = dens_acc;
    s.lam = lam_acc;
    s.fx = force_acc[0];
    s.fy = force_acc[1];
    s.fz = force_acc[2];
    s.zero = flag;
    s.done = last;
    return s;
  endfunction

  // prediction at each input transfer and config write
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 31'(ONE);
      density_q <= 31'(ONE);
      lambda_q <= 31'(ONE);
      for (int i = 0; i < 3; i++) begin
        self_pos[i] = '0;
        self_vel[i] = '0;
        force_acc[i] = '0;
      end
      self_pr = '0;
      dens_acc = '0;
      lam_acc = '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mni_pkg::CFG_RADIUS: radius_q <= cfg_data_i;
          mni_pkg::CFG_DENSITY: density_q <= cfg_data_i;
          mni_pkg::CFG_LAMBDA: lambda_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin : predict
        sums_t s;
        s = interact(action_i, '{pos_x_i, pos_y_i, pos_z_i}, '{vel_x_i, vel_y_i, vel_z_i},
                     pressure_in_i, last_neighbor_i);
        pending_sums.push_back(use_typed ? typed_sums : s);
      end
    end
  end

  // result checking
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin : check
      sums_t e;
      if (pending_sums.size() == 0) begin
        $error("unexpected result transfer");
        fails++;
      end else begin
        e = pending_sums.pop_front();
        if (density_sum_o !== e.dens) begin
          $error("density_sum exp %0d got %0d", e.dens, density_sum_o); fails++;
        end
        if (lambda_sum_o !== e.lam) begin
          $error("lambda_sum exp %0d got %0d", e.lam, lambda_sum_o); fails++;
        end
        if (force_x_o !== e.fx) begin
          $error("force_x exp %0d got %0d", e.fx, force_x_o); fails++;
        end
        if (force_y_o !== e.fy) begin
          $error("force_y exp %0d got %0d", e.fy, force_y_o); fails++;
        end
        if (force_z_o !== e.fz) begin
          $error("force_z exp %0d got %0d", e.fz, force_z_o); fails++;
        end
        if (zero_distance_o !== e.zero) begin
          $error("zero_distance exp %0b got %0b", e.zero, zero_distance_o); fails++;
        end
        if (done_res_o !== e.done) begin
          $error("done_res exp %0b got %0b", e.done, done_res_o); fails++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("mps_neighbor_interaction_tb failed");
      $finish;
    end
  end

  // receiver stall pattern
  int stall_mode, stall_left;
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(10, 200);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 9) < 3);
      default: out_stall_i <= ($urandom_range(0, 19) != 0);
    endcase
  end

  int burst_left;

  task automatic send(row_t t);
    @(negedge clk_i);
    use_typed = t.typed;
    typed_sums = t.want;
    action_i = t.act;
    pos_x_i = t.px; pos_y_i = t.py; pos_z_i = t.pz;
    vel_x_i = t.vx; vel_y_i = t.vy; vel_z_i = t.vz;
    pressure_in_i = t.pr;
    last_neighbor_i = t.last;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      if ($urandom_range(0, 3) != 0) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        repeat ($urandom_range(0, 30)) @(negedge clk_i);
      end
    end
  endtask

  task automatic drain_and_write(logic [1:0] idx, logic [30:0] data);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (pending_sums.size() == 0);
    repeat (20) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic row_t mk(logic [2:0] a, mni_pkg::q_t px, mni_pkg::q_t py,
                              mni_pkg::q_t pz, mni_pkg::q_t pr, logic last);
    row_t t;
    t.act = a;
    t.px = px; t.py = py; t.pz = pz;
    t.vx = $urandom; t.vy = $urandom; t.vz = $urandom;
    t.pr = pr;
    t.last = last;
    t.typed = 0;
    t.want = '0;
    return t;
  endfunction

  function automatic row_t typed(row_t t, mni_pkg::q_t dens, logic zero);
    t.typed = 1;
    t.want = '0;
    t.want.dens = dens;
    t.want.zero = zero;
    t.want.done = t.last;
    return t;
  endfunction

  function automatic mni_pkg::q_t near(mni_pkg::q_t c, logic [30:0] re);
    longint off;
    off = longint'($urandom_range(0, re)) - longint'(re >> 1);
    return mni_pkg::q_t'(longint'(c) + off);
  endfunction

  task automatic random_phase(int count);
    row_t t;
    mni_pkg::q_t cx, cy, cz;
    int n;
    while (count > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        t = mk(3'($urandom), $urandom, $urandom, $urandom, $urandom, 1'($urandom));
        send(t);
        count--;
      end else begin
        cx = $urandom; cy = $urandom; cz = $urandom;
        t = mk(mni_pkg::ACT_LOAD, cx, cy, cz, $urandom, 1'b0);
        send(t);
        n = $urandom_range(1, 12);
        for (int j = 0; j < n; j++) begin
          if ($urandom_range(0, 19) == 0)
            t = mk(3'($urandom_range(1, 4)), cx, cy, cz, $urandom, j == n - 1);
          else
            t = mk(3'($urandom_range(1, 4)), near(cx, radius_q), near(cy, radius_q),
                   near(cz, radius_q), $urandom, j == n - 1);
          send(t);
        end
        count -= n + 1;
      end
    end
  endtask

  row_t rows [$];

  initial begin
    fails = 0;
    idle_cycles = 0;
    stall_left = 0;
    burst_left = 0;
    use_typed = 0;
    typed_sums = '0;
    out_stall_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    action_i = '0;
    {pos_x_i, pos_y_i, pos_z_i, vel_x_i, vel_y_i, vel_z_i, pressure_in_i} = '0;
    last_neighbor_i = 1'b0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    rows.push_back(typed(mk(mni_pkg::ACT_LOAD, 0, 0, 0, 0, 0), 0, 0));
    rows.push_back(typed(mk(mni_pkg::ACT_DENS, 0, 0, 0, 0, 0), 0, 1));
    rows.push_back(typed(mk(mni_pkg::ACT_DENS, 32'sh8000, 0, 0, 0, 0), 32'sh10000, 0));
    rows.push_back(typed(mk(mni_pkg::ACT_DENS, 32'sh20000, 0, 0, 0, 0), 32'sh10000, 0));
    rows.push_back(typed(mk(ACT_SPARE5, 0, 0, 0, 0, 1), 32'sh10000, 0));
    rows.push_back(typed(mk(ACT_SPARE7, 32'sh8000, 0, 0, 0, 0), 32'sh10000, 0));
    rows.push_back(mk(mni_pkg::ACT_LAMBDA, 32'sh4000, 32'sh2000, 0, 0, 0));
    rows.push_back(mk(mni_pkg::ACT_PGRAD, 32'sh4000, -32'sh3000, 32'sh100, mni_pkg::Q_MAX, 0));
    rows.push_back(mk(mni_pkg::ACT_PGRAD, 32'sh10, 0, 0, mni_pkg::Q_MIN, 0));
    rows.push_back(mk(mni_pkg::ACT_VISC, 32'sh1000, 32'sh1000, -32'sh1000, 0, 1));
    rows.push_back(typed(mk(mni_pkg::ACT_LOAD, mni_pkg::Q_MAX, mni_pkg::Q_MAX,
                            mni_pkg::Q_MAX, mni_pkg::Q_MAX, 0), 0, 0));
    rows.push_back(typed(mk(mni_pkg::ACT_DENS, mni_pkg::Q_MIN, mni_pkg::Q_MIN,
                            mni_pkg::Q_MIN, 0, 0), 0, 0));
    rows.push_back(mk(mni_pkg::ACT_VISC, mni_pkg::Q_MAX - 32'sh100, mni_pkg::Q_MAX,
                      mni_pkg::Q_MAX, mni_pkg::Q_MIN, 0));
    rows.push_back(mk(mni_pkg::ACT_PGRAD, mni_pkg::Q_MAX, mni_pkg::Q_MAX - 32'sh10,
                      mni_pkg::Q_MAX, mni_pkg::Q_MIN, 1));
    rows.push_back(typed(mk(mni_pkg::ACT_LOAD, mni_pkg::Q_MIN, mni_pkg::Q_MIN,
                            mni_pkg::Q_MIN, mni_pkg::Q_MIN, 0), 0, 0));
    rows.push_back(mk(mni_pkg::ACT_LAMBDA, mni_pkg::Q_MIN + 32'sh8000, mni_pkg::Q_MIN,
                      mni_pkg::Q_MIN, mni_pkg::Q_MAX, 0));
    rows.push_back(mk(mni_pkg::ACT_VISC, mni_pkg::Q_MIN, mni_pkg::Q_MIN + 32'sh1,
                      mni_pkg::Q_MIN, mni_pkg::Q_MAX, 1));
    foreach (rows[i]) send(rows[i]);
    use_typed = 0;

    random_phase(400);
    drain_and_write(mni_pkg::CFG_RADIUS, 31'h7fffffff);
    drain_and_write(mni_pkg::CFG_DENSITY, 31'h1);
    drain_and_write(mni_pkg::CFG_LAMBDA, 31'h1);
    drain_and_write(CFG_UNUSED, 31'h5555);
    random_phase(400);
    drain_and_write(mni_pkg::CFG_RADIUS, 31'h1);
    drain_and_write(mni_pkg::CFG_DENSITY, 31'h7fffffff);
    drain_and_write(mni_pkg::CFG_LAMBDA, 31'h7fffffff);
    random_phase(300);
    drain_and_write(mni_pkg::CFG_RADIUS, 31'h40000);
    drain_and_write(mni_pkg::CFG_DENSITY, 31'h8000);
    drain_and_write(mni_pkg::CFG_LAMBDA, 31'h30000);
    random_phase(450);
    drain_and_write(mni_pkg::CFG_RADIUS, 31'($urandom_range(1, 32'h00ffffff)));
    drain_and_write(mni_pkg::CFG_DENSITY, 31'($urandom_range(1, 32'h7fffffff)));
    drain_and_write(mni_pkg::CFG_LAMBDA, 31'($urandom_range(1, 32'h000fffff)));
    random_phase(450);

    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (pending_sums.size() == 0);
    repeat (300) @(posedge clk_i);
    if (fails == 0 && pending_sums.size() == 0) begin
      $display("mps_neighbor_interaction_tb passed");
    end else begin
      $display("mps_neighbor_interaction_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
design/mni_pkg.sv
design/mni_div.sv
design/mni_sqrt.sv
design/mps_neighbor_interaction.sv
design/mni_chk.sv
sim/mps_neighbor_interaction_tb.sv
